// ===== sv/ffha_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

    // Geometry: two regions of 64 KiB, 8-byte granules, 8-byte header
    localparam int GRAN_W = 13;
    localparam int MEM_AW = 14;
    localparam int CNT_W  = 17;
    localparam int WANT_W = 14;
    localparam logic [GRAN_W-1:0] END_G       = 13'h1FFF;
    localparam logic [CNT_W-1:0]  END_BYTES   = 17'd65528;
    localparam logic [WANT_W-1:0] SPLIT_MIN_G = 14'd2;

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_ALLOCATED = 2'd0;
    localparam status_t ST_FAILED    = 2'd1;
    localparam status_t ST_FREED     = 2'd2;
    localparam status_t ST_IGNORED   = 2'd3;

    // Datapath micro-operations
    typedef logic [4:0] op_t;
    localparam op_t OP_NONE     = 5'd0;
    localparam op_t OP_CLEAR    = 5'd1;
    localparam op_t OP_LOAD     = 5'd2;
    localparam op_t OP_A_START  = 5'd3;
    localparam op_t OP_A_READ   = 5'd4;
    localparam op_t OP_A_STEP   = 5'd5;
    localparam op_t OP_A_UNLINK = 5'd6;
    localparam op_t OP_A_TAKE   = 5'd7;
    localparam op_t OP_A_NEXTRG = 5'd8;
    localparam op_t OP_F_READ   = 5'd9;
    localparam op_t OP_F_CHECK  = 5'd10;
    localparam op_t OP_I_START  = 5'd11;
    localparam op_t OP_I_READ   = 5'd12;
    localparam op_t OP_I_STEP   = 5'd13;
    localparam op_t OP_I_MERGE  = 5'd14;
    localparam op_t OP_I_NREAD  = 5'd15;
    localparam op_t OP_I_NMERGE = 5'd16;
    localparam op_t OP_I_WRITE  = 5'd17;
    localparam op_t OP_I_LINK   = 5'd18;
    localparam op_t OP_OUT      = 5'd19;

    // One block header in the header memory
    typedef struct packed {
        logic [GRAN_W-1:0] size;
        logic [GRAN_W-1:0] next;
        logic              alloc;
    } hdr_t;

    // Controller to datapath
    typedef struct packed {
        op_t     op;
        status_t status;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_free;
        logic a_ok;
        logic blk_end;
        logic fit;
        logic split;
        logic f_ok;
        logic rd_alloc;
        logic cur_lt_b;
        logic adj_next;
        logic merged;
        logic region1;
        logic out_free;
        logic clr_last;
    } flags_t;

endpackage

// ===== sv/ffha_dpath.sv =====
// Datapath of the heap allocator: header memory, list registers, counts, result register.
module ffha_dpath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic                             cfg_wdata,
    input  logic                             s_cmd,
    input  logic [15:0]                      s_request_bytes,
    input  logic [16:0]                      s_block_address,
    input  ffha_pkg::cmd_t                   cmd_in,
    output ffha_pkg::flags_t                 flags,
    input  logic                             m_ready,
    output logic                             m_valid,
    output logic [1:0]                       m_status,
    output logic [16:0]                      m_granted_address,
    output logic [16:0]                      m_free_bytes_plain,
    output logic [16:0]                      m_free_bytes_dma,
    output logic [16:0]                      m_least_free_plain,
    output logic [16:0]                      m_least_free_dma
);

    localparam int GW = ffha_pkg::GRAN_W;
    localparam int CW = ffha_pkg::CNT_W;
    localparam int WW = ffha_pkg::WANT_W;
    localparam int AW = ffha_pkg::MEM_AW;

    // Header memory, one entry per granule of both regions
    ffha_pkg::hdr_t mem [0:(1<<AW)-1];
    ffha_pkg::hdr_t rdata_reg;
    logic           mem_we;
    logic [AW-1:0]  mem_addr;
    ffha_pkg::hdr_t mem_wdata;

    // Control state
    logic          dma_reg, dma_next;
    logic [GW-1:0] head_reg [0:1];
    logic [GW-1:0] head_next [0:1];
    logic [CW-1:0] free_reg [0:1];
    logic [CW-1:0] free_next [0:1];
    logic [CW-1:0] least_reg [0:1];
    logic [CW-1:0] least_next [0:1];
    logic [AW-1:0] clr_reg, clr_next;
    logic          m_valid_reg, m_valid_next;

    // Working registers
    logic          is_free_reg, is_free_next;
    logic [WW-1:0] wanted_reg, wanted_next;
    logic [16:0]   addr_reg, addr_next;
    logic          region_reg, region_next;
    logic [GW-1:0] prev_reg, prev_next;
    logic          prev_head_reg, prev_head_next;
    logic [GW-1:0] psz_reg, psz_next;
    logic [GW-1:0] blk_reg, blk_next;
    logic [GW-1:0] bsz_reg, bsz_next;
    logic [GW-1:0] bnx_reg, bnx_next;
    logic [GW-1:0] it_reg, it_next;
    logic          it_head_reg, it_head_next;
    logic [GW-1:0] itsz_reg, itsz_next;
    logic [GW-1:0] cur_reg, cur_next;
    logic          merged_reg, merged_next;
    logic [GW-1:0] grant_reg, grant_next;

    // Result register
    logic [1:0]    st_reg, st_next;
    logic [16:0]   ga_reg, ga_next;
    logic [CW-1:0] ofp_reg, ofp_next, ofd_reg, ofd_next;
    logic [CW-1:0] olp_reg, olp_next, old_reg, old_next;

    // Derived values
    logic [WW-1:0] rem_g;
    logic          split;
    logic [GW-1:0] taken_g;
    logic [CW-1:0] free_after;
    logic [WW-1:0] b_end, it_end;
    logic [GW-1:0] f_gran;
    logic [15:0]   grant_off;

    assign rem_g      = {1'b0, bsz_reg} - wanted_reg;
    assign split      = rem_g > ffha_pkg::SPLIT_MIN_G;
    assign taken_g    = split ? wanted_reg[GW-1:0] : bsz_reg;
    assign free_after = free_reg[region_reg] - {1'b0, taken_g, 3'b000};
    assign b_end      = {1'b0, blk_reg} + {1'b0, bsz_reg};
    assign it_end     = {1'b0, it_reg} + {1'b0, itsz_reg};
    assign f_gran     = addr_reg[15:3] - 13'd1;
    assign grant_off  = {grant_reg + 13'd1, 3'b000};

    // Status toward the controller
    always_comb begin
        flags.is_free  = is_free_reg;
        flags.a_ok     = (wanted_reg != '0) && ({wanted_reg, 3'b000} <= free_reg[region_reg]);
        flags.blk_end  = blk_reg == ffha_pkg::END_G;
        flags.fit      = {1'b0, rdata_reg.size} >= wanted_reg;
        flags.split    = split;
        flags.f_ok     = !(!addr_reg[16] && dma_reg) && (addr_reg[15:3] != '0)
                         && (addr_reg[2:0] == 3'b000);
        flags.rd_alloc = rdata_reg.alloc;
        flags.cur_lt_b = cur_reg < blk_reg;
        flags.adj_next = (b_end == {1'b0, cur_reg}) && (cur_reg != ffha_pkg::END_G);
        flags.merged   = merged_reg;
        flags.region1  = region_reg;
        flags.out_free = !m_valid_reg || m_ready;
        flags.clr_last = &clr_reg;
    end

    // Execute one micro-operation per cycle
    always_comb begin
        mem_we         = 1'b0;
        mem_addr       = {region_reg, blk_reg};
        mem_wdata      = '0;
        dma_next       = cfg_we ? cfg_wdata : dma_reg;
        head_next      = head_reg;
        free_next      = free_reg;
        least_next     = least_reg;
        clr_next       = clr_reg;
        m_valid_next   = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        is_free_next   = is_free_reg;
        wanted_next    = wanted_reg;
        addr_next      = addr_reg;
        region_next    = region_reg;
        prev_next      = prev_reg;
        prev_head_next = prev_head_reg;
        psz_next       = psz_reg;
        blk_next       = blk_reg;
        bsz_next       = bsz_reg;
        bnx_next       = bnx_reg;
        it_next        = it_reg;
        it_head_next   = it_head_reg;
        itsz_next      = itsz_reg;
        cur_next       = cur_reg;
        merged_next    = merged_reg;
        grant_next     = grant_reg;
        st_next        = st_reg;
        ga_next        = ga_reg;
        ofp_next       = ofp_reg;
        ofd_next       = ofd_reg;
        olp_next       = olp_reg;
        old_next       = old_reg;
        case (cmd_in.op)
            ffha_pkg::OP_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                if (clr_reg[AW-2:0] == '0) begin
                    mem_wdata.size = ffha_pkg::END_G;
                    mem_wdata.next = ffha_pkg::END_G;
                end
                clr_next = clr_reg + 1'b1;
            end
            ffha_pkg::OP_LOAD: begin
                is_free_next = s_cmd;
                addr_next    = s_block_address;
                region_next  = dma_reg;
                wanted_next  = (s_request_bytes == '0) ? '0
                             : WW'(({1'b0, s_request_bytes} + 17'd15) >> 3);
            end
            ffha_pkg::OP_A_START: begin
                prev_head_next = 1'b1;
                blk_next       = head_reg[region_reg];
            end
            ffha_pkg::OP_A_READ: begin
                mem_addr = {region_reg, blk_reg};
            end
            ffha_pkg::OP_A_STEP: begin
                if ({1'b0, rdata_reg.size} < wanted_reg) begin
                    prev_next      = blk_reg;
                    prev_head_next = 1'b0;
                    psz_next       = rdata_reg.size;
                    blk_next       = rdata_reg.next;
                end else begin
                    bsz_next = rdata_reg.size;
                    bnx_next = rdata_reg.next;
                end
            end
            ffha_pkg::OP_A_UNLINK: begin
                if (prev_head_reg) begin
                    head_next[region_reg] = bnx_reg;
                end else begin
                    mem_we         = 1'b1;
                    mem_addr       = {region_reg, prev_reg};
                    mem_wdata.size = psz_reg;
                    mem_wdata.next = bnx_reg;
                end
            end
            ffha_pkg::OP_A_TAKE: begin
                mem_we                 = 1'b1;
                mem_addr               = {region_reg, blk_reg};
                mem_wdata.size         = taken_g;
                mem_wdata.next         = bnx_reg;
                mem_wdata.alloc        = 1'b1;
                free_next[region_reg]  = free_after;
                if (free_after < least_reg[region_reg]) begin
                    least_next[region_reg] = free_after;
                end
                grant_next = blk_reg;
                if (split) begin
                    blk_next = blk_reg + wanted_reg[GW-1:0];
                    bsz_next = rem_g[GW-1:0];
                end
            end
            ffha_pkg::OP_A_NEXTRG: begin
                region_next = 1'b1;
            end
            ffha_pkg::OP_F_READ: begin
                region_next = addr_reg[16];
                blk_next    = f_gran;
                mem_addr    = {addr_reg[16], f_gran};
            end
            ffha_pkg::OP_F_CHECK: begin
                if (rdata_reg.alloc) begin
                    mem_we                = 1'b1;
                    mem_addr              = {region_reg, blk_reg};
                    mem_wdata.size        = rdata_reg.size;
                    mem_wdata.next        = rdata_reg.next;
                    free_next[region_reg] = free_reg[region_reg]
                                          + {1'b0, rdata_reg.size, 3'b000};
                    bsz_next              = rdata_reg.size;
                end
            end
            ffha_pkg::OP_I_START: begin
                it_head_next = 1'b1;
                cur_next     = head_reg[region_reg];
            end
            ffha_pkg::OP_I_READ: begin
                mem_addr     = {region_reg, cur_reg};
                it_next      = cur_reg;
                it_head_next = 1'b0;
            end
            ffha_pkg::OP_I_STEP: begin
                itsz_next = rdata_reg.size;
                cur_next  = rdata_reg.next;
            end
            ffha_pkg::OP_I_MERGE: begin
                bnx_next = cur_reg;
                if (!it_head_reg && (it_end == {1'b0, blk_reg})) begin
                    blk_next    = it_reg;
                    bsz_next    = itsz_reg + bsz_reg;
                    merged_next = 1'b1;
                end else begin
                    merged_next = 1'b0;
                end
            end
            ffha_pkg::OP_I_NREAD: begin
                mem_addr = {region_reg, cur_reg};
            end
            ffha_pkg::OP_I_NMERGE: begin
                bsz_next = bsz_reg + rdata_reg.size;
                bnx_next = rdata_reg.next;
            end
            ffha_pkg::OP_I_WRITE: begin
                mem_we         = 1'b1;
                mem_addr       = {region_reg, blk_reg};
                mem_wdata.size = bsz_reg;
                mem_wdata.next = bnx_reg;
            end
            ffha_pkg::OP_I_LINK: begin
                if (it_head_reg) begin
                    head_next[region_reg] = blk_reg;
                end else begin
                    mem_we         = 1'b1;
                    mem_addr       = {region_reg, it_reg};
                    mem_wdata.size = itsz_reg;
                    mem_wdata.next = blk_reg;
                end
            end
            ffha_pkg::OP_OUT: begin
                m_valid_next = 1'b1;
                st_next      = cmd_in.status;
                ga_next      = (cmd_in.status == ffha_pkg::ST_ALLOCATED)
                             ? {region_reg, grant_off} : '0;
                ofp_next     = free_reg[0];
                ofd_next     = free_reg[1];
                olp_next     = least_reg[0];
                old_next     = least_reg[1];
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Header memory with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dma_reg     <= 1'b0;
            head_reg    <= '{default: '0};
            free_reg    <= '{default: ffha_pkg::END_BYTES};
            least_reg   <= '{default: ffha_pkg::END_BYTES};
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            dma_reg     <= dma_next;
            head_reg    <= head_next;
            free_reg    <= free_next;
            least_reg   <= least_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and result registers
    always_ff @(posedge aclk) begin
        is_free_reg   <= is_free_next;
        wanted_reg    <= wanted_next;
        addr_reg      <= addr_next;
        region_reg    <= region_next;
        prev_reg      <= prev_next;
        prev_head_reg <= prev_head_next;
        psz_reg       <= psz_next;
        blk_reg       <= blk_next;
        bsz_reg       <= bsz_next;
        bnx_reg       <= bnx_next;
        it_reg        <= it_next;
        it_head_reg   <= it_head_next;
        itsz_reg      <= itsz_next;
        cur_reg       <= cur_next;
        merged_reg    <= merged_next;
        grant_reg     <= grant_next;
        st_reg        <= st_next;
        ga_reg        <= ga_next;
        ofp_reg       <= ofp_next;
        ofd_reg       <= ofd_next;
        olp_reg       <= olp_next;
        old_reg       <= old_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = st_reg;
    assign m_granted_address  = ga_reg;
    assign m_free_bytes_plain = ofp_reg;
    assign m_free_bytes_dma   = ofd_reg;
    assign m_least_free_plain = olp_reg;
    assign m_least_free_dma   = old_reg;

endmodule

// ===== sv/ffha_ctrl.sv =====
// Controller state machine of the heap allocator.
module ffha_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ffha_pkg::flags_t flags,
    output ffha_pkg::cmd_t   cmd_out
);

    localparam logic [4:0] S_CLEAR    = 5'd0;
    localparam logic [4:0] S_IDLE     = 5'd1;
    localparam logic [4:0] S_DISPATCH = 5'd2;
    localparam logic [4:0] S_A_START  = 5'd3;
    localparam logic [4:0] S_A_RD     = 5'd4;
    localparam logic [4:0] S_A_CHK    = 5'd5;
    localparam logic [4:0] S_A_UNLINK = 5'd6;
    localparam logic [4:0] S_A_TAKE   = 5'd7;
    localparam logic [4:0] S_A_FAIL   = 5'd8;
    localparam logic [4:0] S_F_RD     = 5'd9;
    localparam logic [4:0] S_F_CHK    = 5'd10;
    localparam logic [4:0] S_I_START  = 5'd11;
    localparam logic [4:0] S_I_WALK   = 5'd12;
    localparam logic [4:0] S_I_STEP   = 5'd13;
    localparam logic [4:0] S_I_MERGE  = 5'd14;
    localparam logic [4:0] S_I_NEXT   = 5'd15;
    localparam logic [4:0] S_I_NMERGE = 5'd16;
    localparam logic [4:0] S_I_WRITE  = 5'd17;
    localparam logic [4:0] S_I_LINK   = 5'd18;
    localparam logic [4:0] S_OUT      = 5'd19;

    logic [4:0]        state_reg, state_next;
    ffha_pkg::status_t status_reg, status_next;

    assign s_ready = state_reg == S_IDLE;

    // Sequence the datapath
    always_comb begin
        state_next     = state_reg;
        status_next    = status_reg;
        cmd_out.op     = ffha_pkg::OP_NONE;
        cmd_out.status = status_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd_out.op = ffha_pkg::OP_CLEAR;
                if (flags.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd_out.op = ffha_pkg::OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!flags.is_free) begin
                    state_next = S_A_START;
                end else if (flags.f_ok) begin
                    state_next = S_F_RD;
                end else begin
                    status_next = ffha_pkg::ST_IGNORED;
                    state_next  = S_OUT;
                end
            end
            S_A_START: begin
                if (flags.a_ok) begin
                    cmd_out.op = ffha_pkg::OP_A_START;
                    state_next = S_A_RD;
                end else begin
                    state_next = S_A_FAIL;
                end
            end
            S_A_RD: begin
                if (flags.blk_end) begin
                    state_next = S_A_FAIL;
                end else begin
                    cmd_out.op = ffha_pkg::OP_A_READ;
                    state_next = S_A_CHK;
                end
            end
            S_A_CHK: begin
                cmd_out.op = ffha_pkg::OP_A_STEP;
                state_next = flags.fit ? S_A_UNLINK : S_A_RD;
            end
            S_A_UNLINK: begin
                cmd_out.op = ffha_pkg::OP_A_UNLINK;
                state_next = S_A_TAKE;
            end
            S_A_TAKE: begin
                cmd_out.op  = ffha_pkg::OP_A_TAKE;
                status_next = ffha_pkg::ST_ALLOCATED;
                state_next  = flags.split ? S_I_START : S_OUT;
            end
            S_A_FAIL: begin
                // retry in the DMA region once, then give up
                if (!flags.region1) begin
                    cmd_out.op = ffha_pkg::OP_A_NEXTRG;
                    state_next = S_A_START;
                end else begin
                    status_next = ffha_pkg::ST_FAILED;
                    state_next  = S_OUT;
                end
            end
            S_F_RD: begin
                cmd_out.op = ffha_pkg::OP_F_READ;
                state_next = S_F_CHK;
            end
            S_F_CHK: begin
                cmd_out.op = ffha_pkg::OP_F_CHECK;
                if (flags.rd_alloc) begin
                    status_next = ffha_pkg::ST_FREED;
                    state_next  = S_I_START;
                end else begin
                    status_next = ffha_pkg::ST_IGNORED;
                    state_next  = S_OUT;
                end
            end
            S_I_START: begin
                cmd_out.op = ffha_pkg::OP_I_START;
                state_next = S_I_WALK;
            end
            S_I_WALK: begin
                if (flags.cur_lt_b) begin
                    cmd_out.op = ffha_pkg::OP_I_READ;
                    state_next = S_I_STEP;
                end else begin
                    state_next = S_I_MERGE;
                end
            end
            S_I_STEP: begin
                cmd_out.op = ffha_pkg::OP_I_STEP;
                state_next = S_I_WALK;
            end
            S_I_MERGE: begin
                cmd_out.op = ffha_pkg::OP_I_MERGE;
                state_next = S_I_NEXT;
            end
            S_I_NEXT: begin
                if (flags.adj_next) begin
                    cmd_out.op = ffha_pkg::OP_I_NREAD;
                    state_next = S_I_NMERGE;
                end else begin
                    state_next = S_I_WRITE;
                end
            end
            S_I_NMERGE: begin
                cmd_out.op = ffha_pkg::OP_I_NMERGE;
                state_next = S_I_WRITE;
            end
            S_I_WRITE: begin
                cmd_out.op = ffha_pkg::OP_I_WRITE;
                state_next = flags.merged ? S_OUT : S_I_LINK;
            end
            S_I_LINK: begin
                cmd_out.op = ffha_pkg::OP_I_LINK;
                state_next = S_OUT;
            end
            S_OUT: begin
                // hold until the result register is free
                if (flags.out_free) begin
                    cmd_out.op = ffha_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            status_reg <= ffha_pkg::ST_FAILED;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

// ===== sv/first_fit_heap_allocator_core.sv =====
// First-fit two-region heap allocator with coalescing free lists.
// An alloc walks the free list of its region node by node; a fallback from the plain region
// walks the DMA list too (skipped if its count is too small), and a split reinserts the rest
// with a walk of the list. A free walks the list to coalesce; a rejected free ends early.
// One beat is in work at a time, so the walk sets the rate; a held result stalls the output.
// Reset: synchronous, active low; a clearing pass over every header entry blocks beats (config lands).
module first_fit_heap_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [15:0] s_request_bytes,
    input  logic [16:0] s_block_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [16:0] m_granted_address,
    output logic [16:0] m_free_bytes_plain,
    output logic [16:0] m_free_bytes_dma,
    output logic [16:0] m_least_free_plain,
    output logic [16:0] m_least_free_dma
);

    ffha_pkg::cmd_t   cmd;
    ffha_pkg::flags_t flags;

    ffha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .flags   (flags),
        .cmd_out (cmd)
    );

    ffha_dpath u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .s_cmd              (s_cmd),
        .s_request_bytes    (s_request_bytes),
        .s_block_address    (s_block_address),
        .cmd_in             (cmd),
        .flags              (flags),
        .m_ready            (m_ready),
        .m_valid            (m_valid),
        .m_status           (m_status),
        .m_granted_address  (m_granted_address),
        .m_free_bytes_plain (m_free_bytes_plain),
        .m_free_bytes_dma   (m_free_bytes_dma),
        .m_least_free_plain (m_least_free_plain),
        .m_least_free_dma   (m_least_free_dma)
    );

endmodule
